[design/hsog_pkg.sv]
// Shared types, constants and helper functions of the hashed step offset generator.
`default_nettype none

package hsog_pkg;

  // Field and datapath widths.
  localparam int SEED_W     = 32;
  localparam int BOUND_W    = 7;
  localparam int OFFSET_W   = 6;
  localparam int LEVEL_W    = 10;
  localparam int PROD_W     = 18;
  localparam int DIGIT_W    = 8;
  localparam int MOD_STAGES = SEED_W / DIGIT_W;

  // Cycles from the accepting edge to the edge that takes the first result.
  localparam int LATENCY = 6 + MOD_STAGES;

  // Level scaling.
  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 10'd1000;
  localparam logic [7:0]         FLIP_SCALE = 8'd255;

  // Seed folding by repeated multiply-by-31; the square covers two folds at once.
  localparam logic [PROD_W-1:0] MUL_31      = 18'd31;
  localparam logic [PROD_W-1:0] MUL_961     = 18'd961;
  localparam logic [SEED_W-1:0] HASH_MUL    = 32'd31;
  localparam logic [SEED_W-1:0] HASH_MUL_SQ = 32'd961;

  // Finalizer multipliers.
  localparam logic [SEED_W-1:0] FMIX_C1 = 32'h85eb_ca6b;
  localparam logic [SEED_W-1:0] FMIX_C2 = 32'hc2b2_ae35;

  // Division by 1000: floor reciprocal, then one upward correction.
  localparam logic [PROD_W-1:0] DIV_DEN     = 18'd1000;
  localparam logic [PROD_W-1:0] RECIP_1000  = 18'd134217;
  localparam int                RECIP_SHIFT = 27;

  // Operation codes.
  typedef enum logic [1:0] {
    OP_OFFSET     = 2'd0,
    OP_REPEAT     = 2'd1,
    OP_REPEAT_MOD = 2'd2,
    OP_FLIP       = 2'd3
  } op_e;

  // Control bits that travel with each word down the pipeline.
  typedef struct packed {
    logic vld;
    logic zero;
    logic flip_mode;
    logic flip;
    logic last;
  } ctl_t;

  // Eight steps of restoring remainder: shift in one dividend bit, subtract if it fits.
  function automatic logic [BOUND_W-1:0] rem_step(input logic [BOUND_W-1:0] rem_in,
                                                  input logic [DIGIT_W-1:0] bits,
                                                  input logic [BOUND_W-1:0] bound);
    logic [BOUND_W:0]   acc;
    logic [BOUND_W-1:0] r;
    r = rem_in;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      acc = {r, bits[i]};
      if (acc >= {1'b0, bound}) begin
        acc = acc - {1'b0, bound};
      end
      r = acc[BOUND_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/hashed_step_offset_generator_top.sv]
// Top level of the hashed step offset generator.
//
// Usage: raise start_i with an operation and its fields; the word is taken at a
// rising edge where start_i is high and busy_o is low. Offset and flip words give
// one result; both repeat operations give REPEAT_COUNT results for steps 0, 1, ...
// Results appear on offset_o, flip_o and last_o for exactly one cycle while
// valid_o is high; last_o marks the final result of a word. The receiver cannot
// stall, and the pipeline never does either.
// Each word passes six hash and bound stages and then four remainder stages
// before its first result is taken.
// Throughput: one word per cycle for offset and flip words while busy_o is low.
// A repeat word holds busy_o high while the issue counter feeds its further
// steps into the pipeline, so no new word is taken until its last step is issued;
// its results come out on consecutive cycles.
// Reset clears the issue counter and all pipeline valid bits; words in flight
// are dropped. There is no configuration and no state between words.
`default_nettype none

module hashed_step_offset_generator_top #(
  parameter int MAX_STEPS    = 64,
  parameter int REPEAT_COUNT = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  step_index_i,
  input  logic [7:0]  track_number_i,
  input  logic [9:0]  level_milli_i,
  input  logic [6:0]  step_count_i,
  input  logic [63:0] global_counter_i,
  input  logic [31:0] modifier_i,
  output logic        valid_o,
  output logic [5:0]  offset_o,
  output logic        flip_o,
  output logic        last_o
);
  import hsog_pkg::*;

  localparam int CntW = $clog2(REPEAT_COUNT + 1);
  localparam logic [CntW-1:0] LastIdx = CntW'(REPEAT_COUNT - 1);

  typedef struct packed {
    logic [7:0]  step;
    logic [7:0]  track;
    logic [9:0]  level;
    logic [6:0]  steps;
    logic [63:0] ent;
    logic [31:0] modifier;
    logic        use_mod;
  } sub_t;

  // Issue stage signals.
  op_e             op;
  logic            accept;
  logic            is_rep;
  logic [6:0]      steps_sat;
  sub_t            new_sub;
  ctl_t            new_ctl;
  logic [CntW-1:0] cnt_q, cnt_d;
  sub_t            hold_q;
  logic            hold_zero_q;

  // Pipeline registers.
  sub_t               s1_q, s1_d;
  ctl_t               c1_q, c1_d, c2_q, c3_q, c4_q, c5_q, c6_q, c6_d;
  logic [PROD_W-1:0]  t2_q, t2_d, p2_q, p2_d, p3_q;
  logic [SEED_W-1:0]  lo2_q, lo2_d, hi2_q, modx2_q, modx2_d, modx3_q, modx4_q, modx5_q;
  logic [SEED_W-1:0]  h3_q, h3_d, h4_q, h4_d, h5_q, h5_d, seed6_q, seed6_d;
  logic [7:0]         q0_3_q, q0_3_d, q4_q, q4_d, q5_q;
  logic [BOUND_W-1:0] bound6_q, bound6_d;

  // Stage-local combinational values.
  logic [LEVEL_W-1:0]  lsat1;
  logic [7:0]          fac1;
  logic [35:0]         prod2;
  logic [SEED_W-1:0]   x3, x4, x5;
  logic [PROD_W-1:0]   rem3;

  // Remainder unit outputs.
  ctl_t               ctl_out;
  logic [BOUND_W-1:0] rem_out;

  // Decode a new word into the first sub-item.
  always_comb begin
    op        = op_e'(operation_i);
    is_rep    = (op == OP_REPEAT) || (op == OP_REPEAT_MOD);
    steps_sat = ({25'd0, step_count_i} > 32'(MAX_STEPS)) ? 7'(MAX_STEPS) : step_count_i;

    new_sub.step     = is_rep ? 8'd0 : step_index_i;
    new_sub.track    = track_number_i;
    new_sub.level    = level_milli_i;
    new_sub.steps    = steps_sat;
    new_sub.ent      = (op == OP_OFFSET) ? global_counter_i : 64'd0;
    new_sub.modifier = modifier_i;
    new_sub.use_mod  = (op == OP_REPEAT_MOD);

    new_ctl.vld       = 1'b1;
    new_ctl.flip_mode = (op == OP_FLIP);
    new_ctl.flip      = 1'b0;
    new_ctl.last      = !is_rep || (REPEAT_COUNT == 1);
    case (op)
      OP_OFFSET:     new_ctl.zero = (level_milli_i == '0) || (steps_sat == '0);
      OP_REPEAT:     new_ctl.zero = (steps_sat == '0);
      OP_REPEAT_MOD: new_ctl.zero = (steps_sat == '0);
      default:       new_ctl.zero = 1'b0;
    endcase
  end

  assign busy_o = (cnt_q != '0);
  assign accept = start_i && !busy_o;

  // Issue: a new word, or the next step of a repeat word in progress.
  always_comb begin
    if (busy_o) begin
      s1_d            = hold_q;
      s1_d.step       = 8'(cnt_q);
      c1_d.vld        = 1'b1;
      c1_d.zero       = hold_zero_q;
      c1_d.flip_mode  = 1'b0;
      c1_d.flip       = 1'b0;
      c1_d.last       = (cnt_q == LastIdx);
      cnt_d           = (cnt_q == LastIdx) ? '0 : cnt_q + CntW'(1);
    end else begin
      s1_d     = new_sub;
      c1_d     = new_ctl;
      c1_d.vld = accept;
      cnt_d    = (accept && is_rep && (REPEAT_COUNT > 1)) ? CntW'(1) : cnt_q;
    end
  end

  // Stage 2: partial seed fold, low entropy word and modifier times 31, bound or threshold product.
  always_comb begin
    lsat1   = (s1_q.level > LEVEL_FULL) ? LEVEL_FULL : s1_q.level;
    fac1    = c1_q.flip_mode ? FLIP_SCALE : {1'b0, s1_q.steps - 7'd1};
    p2_d    = PROD_W'(lsat1) * PROD_W'(fac1);
    t2_d    = PROD_W'(s1_q.step) * MUL_961 + PROD_W'(s1_q.track) * MUL_31
            + PROD_W'(s1_q.level);
    lo2_d   = s1_q.ent[31:0] * HASH_MUL;
    modx2_d = s1_q.use_mod ? s1_q.modifier * HASH_MUL : '0;
  end

  // Stage 3: complete seed fold with two more multiply-by-31 steps; estimate the
  // quotient by 1000.
  always_comb begin
    h3_d   = SEED_W'(t2_q) * HASH_MUL_SQ + lo2_q + hi2_q;
    prod2  = 36'(p2_q) * 36'(RECIP_1000);
    q0_3_d = prod2[RECIP_SHIFT +: 8];
  end

  // Stage 4: first finalizer round; correct the quotient estimate.
  always_comb begin
    x3   = h3_q ^ (h3_q >> 16);
    h4_d = x3 * FMIX_C1;
    rem3 = p3_q - PROD_W'(q0_3_q) * DIV_DEN;
    q4_d = q0_3_q + {7'd0, (rem3 >= DIV_DEN)};
  end

  // Stage 5: second finalizer round.
  always_comb begin
    x4   = h4_q ^ (h4_q >> 13);
    h5_d = x4 * FMIX_C2;
  end

  // Stage 6: final shift, modifier mix, flip compare and offset bound.
  always_comb begin
    x5          = h5_q ^ (h5_q >> 16);
    seed6_d     = x5 ^ modx5_q;
    bound6_d    = q5_q[BOUND_W-1:0] + 7'd1;
    c6_d        = c5_q;
    c6_d.flip   = c5_q.flip_mode && (seed6_d[7:0] < q5_q);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      c1_q  <= '0;
      c2_q  <= '0;
      c3_q  <= '0;
      c4_q  <= '0;
      c5_q  <= '0;
      c6_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      c1_q  <= c1_d;
      c2_q  <= c1_q;
      c3_q  <= c2_q;
      c4_q  <= c3_q;
      c5_q  <= c4_q;
      c6_q  <= c6_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q      <= new_sub;
      hold_zero_q <= new_ctl.zero;
    end
    s1_q     <= s1_d;
    t2_q     <= t2_d;
    p2_q     <= p2_d;
    lo2_q    <= lo2_d;
    hi2_q    <= s1_q.ent[63:32];
    modx2_q  <= modx2_d;
    h3_q     <= h3_d;
    p3_q     <= p2_q;
    q0_3_q   <= q0_3_d;
    modx3_q  <= modx2_q;
    h4_q     <= h4_d;
    q4_q     <= q4_d;
    modx4_q  <= modx3_q;
    h5_q     <= h5_d;
    q5_q     <= q4_q;
    modx5_q  <= modx4_q;
    seed6_q  <= seed6_d;
    bound6_q <= bound6_d;
  end

  // Seed modulo bound.
  hsog_mod u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (c6_q),
    .seed_i  (seed6_q),
    .bound_i (bound6_q),
    .ctl_o   (ctl_out),
    .rem_o   (rem_out)
  );

  // Result word.
  assign valid_o  = ctl_out.vld;
  assign last_o   = ctl_out.vld && ctl_out.last;
  assign flip_o   = ctl_out.vld && ctl_out.flip;
  assign offset_o = (ctl_out.vld && !ctl_out.zero && !ctl_out.flip_mode)
                  ? rem_out[OFFSET_W-1:0] : '0;

endmodule

`default_nettype wire

[design/hsog_mod.sv]
// Pipelined remainder unit: seed modulo a small bound, one byte of the seed per stage.
`default_nettype none

module hsog_mod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hsog_pkg::ctl_t                ctl_i,
  input  logic [hsog_pkg::SEED_W-1:0]   seed_i,
  input  logic [hsog_pkg::BOUND_W-1:0]  bound_i,
  output hsog_pkg::ctl_t                ctl_o,
  output logic [hsog_pkg::BOUND_W-1:0]  rem_o
);
  import hsog_pkg::*;

  ctl_t               ctl_q [MOD_STAGES];
  ctl_t               ctl_d [MOD_STAGES];
  logic [SEED_W-1:0]  num_q [MOD_STAGES];
  logic [SEED_W-1:0]  num_in [MOD_STAGES];
  logic [BOUND_W-1:0] bnd_q [MOD_STAGES];
  logic [BOUND_W-1:0] bnd_in [MOD_STAGES];
  logic [BOUND_W-1:0] rem_q [MOD_STAGES];
  logic [BOUND_W-1:0] rem_in [MOD_STAGES];
  logic [BOUND_W-1:0] rem_d [MOD_STAGES];

  // Each stage takes the previous stage's partial remainder and the next seed byte.
  always_comb begin
    for (int g = 0; g < MOD_STAGES; g++) begin
      if (g == 0) begin
        ctl_d[g]  = ctl_i;
        num_in[g] = seed_i;
        bnd_in[g] = bound_i;
        rem_in[g] = '0;
      end else begin
        ctl_d[g]  = ctl_q[g-1];
        num_in[g] = num_q[g-1];
        bnd_in[g] = bnd_q[g-1];
        rem_in[g] = rem_q[g-1];
      end
      rem_d[g] = rem_step(rem_in[g], num_in[g][SEED_W-1 -: DIGIT_W], bnd_in[g]);
    end
  end

  // Control bits of every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g < MOD_STAGES; g++) begin
        ctl_q[g] <= '0;
      end
    end else begin
      for (int g = 0; g < MOD_STAGES; g++) begin
        ctl_q[g] <= ctl_d[g];
      end
    end
  end

  // Datapath of every stage; the consumed byte is shifted out.
  always_ff @(posedge clk_i) begin
    for (int g = 0; g < MOD_STAGES; g++) begin
      num_q[g] <= num_in[g] << DIGIT_W;
      bnd_q[g] <= bnd_in[g];
      rem_q[g] <= rem_d[g];
    end
  end

  assign ctl_o = ctl_q[MOD_STAGES-1];
  assign rem_o = rem_q[MOD_STAGES-1];

endmodule

`default_nettype wire

[design/hsog_checker.sv]
// Port-level checks of the hashed step offset generator, bound to its top level.
`default_nettype none

module hsog_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [1:0] operation_i,
  input logic       valid_o,
  input logic [5:0] offset_o,
  input logic       flip_o,
  input logic       last_o
);
  import hsog_pkg::*;

  // Busy only follows an accepted repeat word.
  busy_from_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i && (operation_i == OP_REPEAT ||
                                        operation_i == OP_REPEAT_MOD)))
    else $error("busy rose without an accepted repeat word");

  // Every accepted word yields a result after the fixed latency.
  fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(start_i && !busy_o && rst_ni, LATENCY) |-> valid_o)
    else $error("no result at the expected latency");

  // Results of one word come out on consecutive cycles.
  burst_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |=> valid_o)
    else $error("gap inside a multi-result word");

  // A flip result is a single, final result with zero offset.
  flip_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flip_o |-> valid_o && last_o && offset_o == '0)
    else $error("flip result malformed");

endmodule

bind hashed_step_offset_generator_top hsog_checker u_hsog_checker (.*);

`default_nettype wire
